### hw/rtl/isswb_pkg.sv
// ----------------------------------------------------------------------------
// isswb_pkg
// Shared types, constants and the sensor unit base table for the bridge.
// ----------------------------------------------------------------------------
package isswb_pkg;

	localparam int unsigned NumUnitsDefault = 23;
	localparam int unsigned TableSize       = 23;

	localparam logic [7:0] WinLowLast   = 8'h2b;
	localparam logic [7:0] WinHighFirst = 8'h40;
	localparam logic [7:0] WinHighLast  = 8'h43;
	localparam logic [1:0] LaneLast     = 2'h3;

	typedef enum logic [1:0] {
		MODE_WRITE_START = 2'd0,
		MODE_WRITE_BYTE  = 2'd1,
		MODE_READ_DONE   = 2'd2,
		MODE_READ_START  = 2'd3
	} mode_t;

	typedef struct packed {
		logic [6:0]  fetch_offset;
		logic [30:0] fetch_base;
		logic        fetch_strobe;
		logic [7:0]  read_byte;
	} result_t;

	function automatic logic [30:0] unit_base(input logic [4:0] idx);
		logic [31:0] b;
		b = 32'h0;
		case (idx)
			5'd0:    b = 32'h04030000;
			5'd1:    b = 32'h08030000;
			5'd2:    b = 32'h0c030000;
			5'd3:    b = 32'h10030000;
			5'd4:    b = 32'h14030000;
			5'd5:    b = 32'h18030000;
			5'd6:    b = 32'h1c030000;
			5'd7:    b = 32'h20030000;
			5'd8:    b = 32'h24030000;
			5'd9:    b = 32'h28030000;
			5'd10:   b = 32'h2c030000;
			5'd11:   b = 32'h30030000;
			5'd12:   b = 32'h38030000;
			5'd13:   b = 32'h3c030000;
			5'd14:   b = 32'h44030000;
			5'd15:   b = 32'h48030000;
			5'd16:   b = 32'h4c030000;
			5'd17:   b = 32'h50030000;
			5'd18:   b = 32'h54030000;
			5'd19:   b = 32'h58030000;
			5'd20:   b = 32'h60030000;
			5'd21:   b = 32'h64030000;
			5'd22:   b = 32'h68030000;
			default: b = 32'h0;
		endcase
		return b[30:0];
	endfunction

	function automatic logic in_window(input logic [7:0] p);
		return (p <= WinLowLast) || ((p >= WinHighFirst) && (p <= WinHighLast));
	endfunction

endpackage

### hw/rtl/isswb_core.sv
// ----------------------------------------------------------------------------
// isswb_core
// Register pointer, unit select and word cache; answers one event per request.
// ----------------------------------------------------------------------------
module isswb_core #(
	parameter int unsigned NUM_UNITS = isswb_pkg::NumUnitsDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [1:0]          mode,
	input  logic [7:0]          data_byte,
	input  logic [31:0]         fetched_word,
	output isswb_pkg::result_t  result
);
	import isswb_pkg::*;

	logic [7:0]  reg_pointer_q;
	logic [4:0]  unit_select_q;
	logic [31:0] cached_word_q;
	logic        cache_valid_q;
	logic [1:0]  write_byte_count_q;

	logic [7:0]  ptr_d;
	logic [4:0]  unit_d;
	logic [31:0] word_d;
	logic        valid_d;
	logic [1:0]  count_d;
	logic        valid_eff;
	logic [31:0] word_src;
	result_t     res;

	always_comb begin
		ptr_d     = reg_pointer_q;
		unit_d    = unit_select_q;
		word_d    = cached_word_q;
		valid_d   = cache_valid_q;
		count_d   = write_byte_count_q;
		valid_eff = cache_valid_q;
		word_src  = cached_word_q;
		res       = '0;
		case (mode_t'(mode))
			MODE_WRITE_START: begin
				count_d = 2'd0;
			end
			MODE_WRITE_BYTE: begin
				if (write_byte_count_q == 2'd0) begin
					ptr_d   = data_byte;
					word_d  = 32'h0;
					valid_d = 1'b0;
					count_d = 2'd1;
				end else if (write_byte_count_q == 2'd1) begin
					if (data_byte < 8'(NUM_UNITS))
						unit_d = data_byte[4:0];
					count_d = 2'd2;
				end
			end
			default: begin
				if (mode_t'(mode) == MODE_READ_DONE) begin
					if (reg_pointer_q[1:0] == LaneLast)
						valid_eff = 1'b0;
					ptr_d = reg_pointer_q + 8'd1;
				end
				valid_d = valid_eff;
				if (!in_window(ptr_d)) begin
					valid_d = 1'b0;
				end else begin
					if (!valid_eff) begin
						word_d           = fetched_word;
						word_src         = fetched_word;
						valid_d          = 1'b1;
						res.fetch_strobe = 1'b1;
						res.fetch_base   = unit_base(unit_select_q);
						res.fetch_offset = {ptr_d[6:2], 2'b00};
					end
					case (ptr_d[1:0])
						2'd0:    res.read_byte = word_src[7:0];
						2'd1:    res.read_byte = word_src[15:8];
						2'd2:    res.read_byte = word_src[23:16];
						default: res.read_byte = word_src[31:24];
					endcase
				end
			end
		endcase
	end

	assign result = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_pointer_q      <= '0;
			unit_select_q      <= '0;
			cached_word_q      <= '0;
			cache_valid_q      <= 1'b0;
			write_byte_count_q <= '0;
		end else if (fire) begin
			reg_pointer_q      <= ptr_d;
			unit_select_q      <= unit_d;
			cached_word_q      <= word_d;
			cache_valid_q      <= valid_d;
			write_byte_count_q <= count_d;
		end
	end

endmodule

### hw/rtl/i2c_slave_sensor_window_bridge.sv
// ----------------------------------------------------------------------------
// i2c_slave_sensor_window_bridge
// I2C slave register window onto the sensor units, one bus event per request.
//
// channel  dir  tdata                                   tuser
// s_axis   in   data_byte, fetched_word (40 bits)       mode (2 bits)
// m_axis   out  read_byte, fetch_base, fetch_offset     fetch_strobe (1 bit)
//
// each request is handled combinationally; its result is registered into
// the result register, or into the skid when m_axis is stalled. a two-entry
// output stage (result register plus skid) keeps s_tready high for one
// stalled result; a new request is taken every cycle while the skid is
// empty. reset clears the pointer, unit select and cache.
// ----------------------------------------------------------------------------
module i2c_slave_sensor_window_bridge #(
	parameter int unsigned NUM_UNITS = isswb_pkg::NumUnitsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // data_byte[7:0], fetched_word[39:8]
	input  logic [1:0]  s_tuser,   // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // read_byte[7:0], fetch_base[38:8], fetch_offset[45:39]
	output logic        m_tuser    // fetch_strobe
);
	import isswb_pkg::*;

	logic    fire;
	logic    out_free;
	result_t new_res;
	result_t out_q;
	result_t skid_q;
	logic    out_valid_q;
	logic    skid_valid_q;

	assign s_tready = !skid_valid_q;
	assign fire     = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	isswb_core #(
		.NUM_UNITS (NUM_UNITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.mode         (s_tuser),
		.data_byte    (s_tdata[7:0]),
		.fetched_word (s_tdata[39:8]),
		.result       (new_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || fire;
			skid_valid_q <= 1'b0;
		end else if (fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : new_res;
		end else if (fire) begin
			skid_q <= new_res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_q.fetch_offset, out_q.fetch_base, out_q.read_byte};
	assign m_tuser  = out_q.fetch_strobe;

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the I2C slave sensor window bridge. An in-bench model of the
// pointer, unit select and word cache predicts each answer. Directed event
// sequences cover the corners first. Randomized write/read transactions
// follow, mixed with stray events. The request side sends in bursts and the
// answer side stalls on a shifting pattern. Answers are compared field by
// field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import isswb_pkg::*;

	localparam int unsigned EVENT_TARGET = 1150;
	localparam int unsigned UNIT_LIMIT   = NumUnitsDefault;
	localparam int unsigned BASE_ENTRIES = 23;
	localparam logic [31:0] SENSOR_BASE [BASE_ENTRIES] = '{
		32'h04030000, 32'h08030000, 32'h0c030000, 32'h10030000, 32'h14030000,
		32'h18030000, 32'h1c030000, 32'h20030000, 32'h24030000, 32'h28030000,
		32'h2c030000, 32'h30030000, 32'h38030000, 32'h3c030000, 32'h44030000,
		32'h48030000, 32'h4c030000, 32'h50030000, 32'h54030000, 32'h58030000,
		32'h60030000, 32'h64030000, 32'h68030000
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;   // data_byte[7:0], fetched_word[39:8]
	logic [1:0]  s_tuser = '0;   // mode[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;        // read_byte[7:0], fetch_base[38:8], fetch_offset[45:39]
	logic        m_tuser;        // fetch_strobe

	i2c_slave_sensor_window_bridge dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// model state
	logic [7:0]  ptr_q;
	logic [4:0]  unit_q;
	logic [31:0] word_cache_q;
	logic        cache_ok_q;
	logic [1:0]  wr_count_q;

	result_t     answer_q[$];
	int unsigned event_count;
	int unsigned mismatch_count;
	int unsigned burst_left;
	bit          no_gaps;

	function automatic bit ptr_in_window(input logic [7:0] p);
		return (p <= WinLowLast) || ((p >= WinHighFirst) && (p <= WinHighLast));
	endfunction

	task automatic serve_read(input logic [31:0] fetched, inout result_t r);
		logic [31:0] base;
		base = '0;
		if (!ptr_in_window(ptr_q)) begin
			cache_ok_q = 1'b0;
		end else begin
			if (!cache_ok_q) begin
				if (unit_q < BASE_ENTRIES)
					base = SENSOR_BASE[unit_q];
				word_cache_q = fetched;
				cache_ok_q = 1'b1;
				r.fetch_strobe = 1'b1;
				r.fetch_base = base[30:0];
				r.fetch_offset = {ptr_q[6:2], 2'b00};
			end
			r.read_byte = word_cache_q[8 * ptr_q[1:0] +: 8];
		end
	endtask

	task automatic predict_event(input mode_t m, input logic [7:0] b, input logic [31:0] w,
			output result_t r, output bit ignored);
		r = '0;
		ignored = 1'b0;
		case (m)
			MODE_WRITE_START: begin
				wr_count_q = 2'd0;
			end
			MODE_WRITE_BYTE: begin
				if (wr_count_q == 2'd0) begin
					ptr_q = b;
					word_cache_q = '0;
					cache_ok_q = 1'b0;
					wr_count_q = 2'd1;
				end else if (wr_count_q == 2'd1) begin
					if (b < UNIT_LIMIT)
						unit_q = b[4:0];
					wr_count_q = 2'd2;
				end else begin
					ignored = 1'b1;
				end
			end
			MODE_READ_DONE: begin
				if (ptr_q[1:0] == LaneLast)
					cache_ok_q = 1'b0;
				ptr_q = ptr_q + 8'd1;
				serve_read(w, r);
			end
			default: begin
				serve_read(w, r);
			end
		endcase
	endtask

	task automatic send_event(input mode_t m, input logic [7:0] b, input logic [31:0] w);
		int unsigned gap;
		result_t     r;
		bit          ignored;
		bit          taken;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			repeat (gap) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		burst_left = burst_left - 1;
		s_tvalid <= 1'b1;
		s_tuser <= m;
		s_tdata <= {w, b};
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			if (s_tready) begin
				taken = 1'b1;
				predict_event(m, b, w, r, ignored);
				answer_q.push_back(r);
				if (!ignored)
					event_count = event_count + 1;
			end
			@(posedge clk);
		end
	endtask

	task automatic set_pointer(input logic [7:0] p);
		send_event(MODE_WRITE_START, 8'($urandom_range(0, 255)), $urandom());
		send_event(MODE_WRITE_BYTE, p, $urandom());
	endtask

	// answer side stall pattern
	logic [15:0] stall_pat = 16'hffff;
	logic [3:0]  stall_ph = '0;

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= stall_pat[stall_ph];
			stall_ph <= stall_ph + 4'd1;
			if (stall_ph == 4'hf) begin
				if ($urandom_range(0, 3) == 0)
					stall_pat <= 16'hffff;
				else
					stall_pat <= 16'($urandom()) | 16'h0101;
			end
		end
	end

	always @(negedge clk) begin : answer_check
		result_t got;
		result_t want;
		got.read_byte = m_tdata[7:0];
		got.fetch_base = m_tdata[38:8];
		got.fetch_offset = m_tdata[45:39];
		got.fetch_strobe = m_tuser;
		if (arst_n && m_tvalid && m_tready) begin
			if (answer_q.size() == 0) begin
				mismatch_count = mismatch_count + 1;
				if (mismatch_count <= 10)
					$display({"tb: answer with no request pending: ",
						"byte %h strobe %b base %h off %h"},
						got.read_byte, got.fetch_strobe, got.fetch_base, got.fetch_offset);
			end else begin
				want = answer_q.pop_front();
				if (got.read_byte !== want.read_byte || got.fetch_strobe !== want.fetch_strobe ||
						got.fetch_base !== want.fetch_base ||
						got.fetch_offset !== want.fetch_offset) begin
					mismatch_count = mismatch_count + 1;
					if (mismatch_count <= 10)
						$display({"tb: mismatch exp byte %h strobe %b base %h off %h, ",
							"act byte %h strobe %b base %h off %h"},
							want.read_byte, want.fetch_strobe, want.fetch_base,
							want.fetch_offset, got.read_byte, got.fetch_strobe,
							got.fetch_base, got.fetch_offset);
				end
			end
		end
	end

	// reads before any write use pointer zero and unit zero
	task automatic test_read_after_reset();
		send_event(MODE_READ_START, 8'h00, 32'hffffffff);
		send_event(MODE_READ_DONE, 8'hff, 32'h00000000);
		send_event(MODE_READ_DONE, 8'h00, 32'h12345678);
		send_event(MODE_READ_DONE, 8'h00, 32'h00000000);
		send_event(MODE_READ_DONE, 8'h00, 32'hffffffff);
	endtask

	// outside the window, wrap at 255, leaving the high window
	task automatic test_pointer_window();
		set_pointer(8'hff);
		send_event(MODE_READ_START, 8'h00, 32'hdeadbeef);
		send_event(MODE_READ_DONE, 8'h00, 32'hffffffff);
		set_pointer(8'h2c);
		send_event(MODE_READ_START, 8'h00, 32'h55aa55aa);
		set_pointer(8'h42);
		send_event(MODE_READ_START, 8'h00, 32'ha5a5a5a5);
		send_event(MODE_READ_DONE, 8'h00, 32'h0);
		send_event(MODE_READ_DONE, 8'h00, 32'h0);
	endtask

	// unit select range and bytes past the second
	task automatic test_unit_select();
		set_pointer(8'h2b);
		send_event(MODE_WRITE_BYTE, 8'd22, 32'h0);
		send_event(MODE_WRITE_BYTE, 8'h00, 32'h0);
		send_event(MODE_READ_START, 8'h00, 32'hcafef00d);
		send_event(MODE_READ_DONE, 8'h00, 32'h0badf00d);
		set_pointer(8'h40);
		send_event(MODE_WRITE_BYTE, 8'd23, 32'h0);
		send_event(MODE_READ_START, 8'h00, 32'h87654321);
		set_pointer(8'h3f);
		send_event(MODE_WRITE_BYTE, 8'hff, 32'h0);
		send_event(MODE_READ_DONE, 8'h00, 32'hffffffff);
	endtask

	task automatic test_random_transactions();
		int unsigned n;
		int unsigned sel;
		logic [7:0]  p;
		while (event_count < EVENT_TARGET) begin
			no_gaps = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 99) < 85) begin
				sel = $urandom_range(0, 9);
				if (sel < 6)
					p = 8'($urandom_range(0, 8'h2b));
				else if (sel < 8)
					p = 8'($urandom_range(8'h40, 8'h43));
				else
					p = 8'($urandom_range(0, 255));
				set_pointer(p);
				if ($urandom_range(0, 9) < 8) begin
					if ($urandom_range(0, 9) < 9)
						send_event(MODE_WRITE_BYTE,
							8'($urandom_range(0, UNIT_LIMIT - 1)), $urandom());
					else
						send_event(MODE_WRITE_BYTE,
							8'($urandom_range(UNIT_LIMIT, 255)), $urandom());
					if ($urandom_range(0, 6) == 0)
						repeat ($urandom_range(1, 2))
							send_event(MODE_WRITE_BYTE, 8'($urandom_range(0, 255)),
								$urandom());
				end
				if ($urandom_range(0, 9) < 7)
					send_event(MODE_READ_START, 8'($urandom_range(0, 255)), $urandom());
				n = $urandom_range(0, 9);
				repeat (n)
					send_event(MODE_READ_DONE, 8'($urandom_range(0, 255)), $urandom());
			end else begin
				n = $urandom_range(1, 6);
				repeat (n)
					send_event(mode_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
						$urandom());
			end
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		ptr_q = '0;
		unit_q = '0;
		word_cache_q = '0;
		cache_ok_q = 1'b0;
		wr_count_q = '0;
		event_count = 0;
		mismatch_count = 0;
		burst_left = 0;
		no_gaps = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_read_after_reset();
		test_pointer_window();
		test_unit_select();
		test_random_transactions();
		s_tvalid <= 1'b0;
		while (answer_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

endmodule

### sim.f
hw/rtl/isswb_pkg.sv
hw/rtl/isswb_core.sv
hw/rtl/i2c_slave_sensor_window_bridge.sv
sim/testbench.sv
